/* rtl/oal_pkg.sv */
`default_nettype none

package oal_pkg;

    localparam logic [2:0] REQ_INS_AT    = 3'd0;
    localparam logic [2:0] REQ_INS_FRONT = 3'd1;
    localparam logic [2:0] REQ_INS_REAR  = 3'd2;
    localparam logic [2:0] REQ_DELETE    = 3'd3;
    localparam logic [2:0] REQ_SEARCH    = 3'd4;
    localparam logic [2:0] REQ_READ      = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 9;
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_SHIFT,
        S_UP_DRAIN,
        S_UP_WRITE,
        S_SCAN,
        S_DN_SHIFT,
        S_DN_DRAIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic        load;
        logic        init_up;
        logic        init_dn;
        logic        init_scan;
        logic        step_up;
        logic        step_dn;
        logic        scan_rd;
        logic        rd_pos;
        logic        wr_new;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        st_we;
        logic [1:0]  st_code;
        logic        respond;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0]  req;
        logic        full;
        logic        ins_bad;
        logic        rd_bad;
        logic        hit;
        logic        scan_end;
        logic        cmp_busy;
        logic        up_more;
        logic        dn_more;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/oal_ram.sv */
`default_nettype none

module oal_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/oal_ctrl.sv */
`default_nettype none

module oal_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire oal_pkg::t_dp_sts i_sts,
    output oal_pkg::t_dp_cmd      o_cmd
);

    import oal_pkg::*;

    t_state r_state;
    t_state n_state;

    logic is_insert;

    assign is_insert = (i_sts.req == REQ_INS_AT) || (i_sts.req == REQ_INS_FRONT) ||
                       (i_sts.req == REQ_INS_REAR);
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (is_insert) begin
                    n_state = (i_sts.full || i_sts.ins_bad) ? S_RESP : S_UP_SHIFT;
                end else if ((i_sts.req == REQ_DELETE) || (i_sts.req == REQ_SEARCH)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UP_SHIFT: begin
                if (!i_sts.up_more) begin
                    n_state = S_UP_DRAIN;
                end
            end
            S_UP_DRAIN: n_state = S_UP_WRITE;
            S_UP_WRITE: n_state = S_RESP;
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = (i_sts.req == REQ_DELETE) ? S_DN_SHIFT : S_RESP;
                end else if (i_sts.scan_end && !i_sts.cmp_busy) begin
                    n_state = S_RESP;
                end
            end
            S_DN_SHIFT: begin
                if (!i_sts.dn_more) begin
                    n_state = S_DN_DRAIN;
                end
            end
            S_DN_DRAIN: n_state = S_RESP;
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DECODE: begin
                o_cmd.st_we = 1'b1;
                if (is_insert) begin
                    if (i_sts.full) begin
                        o_cmd.st_code = ST_FULL;
                    end else if (i_sts.ins_bad) begin
                        o_cmd.st_code = ST_BADPOS;
                    end else begin
                        o_cmd.init_up = 1'b1;
                    end
                end else if ((i_sts.req == REQ_DELETE) || (i_sts.req == REQ_SEARCH)) begin
                    o_cmd.init_scan = 1'b1;
                end else if (i_sts.req == REQ_READ) begin
                    if (i_sts.rd_bad) begin
                        o_cmd.st_code = ST_BADPOS;
                    end else begin
                        o_cmd.rd_pos = 1'b1;
                    end
                end
            end
            S_UP_SHIFT: begin
                o_cmd.step_up = i_sts.up_more;
            end
            S_UP_DRAIN: begin
            end
            S_UP_WRITE: begin
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.init_dn = 1'b1;
                end else if (i_sts.scan_end) begin
                    if (!i_sts.cmp_busy) begin
                        o_cmd.st_we   = 1'b1;
                        o_cmd.st_code = ST_NOTFOUND;
                    end
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_DN_SHIFT: begin
                o_cmd.step_dn = i_sts.dn_more;
            end
            S_DN_DRAIN: begin
                o_cmd.cnt_dec = 1'b1;
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/oal_dp.sv */
`default_nettype none

module oal_dp #(
    parameter int unsigned CAPACITY = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [oal_pkg::REQ_W-1:0]             i_req_type,
    input  wire logic signed [oal_pkg::DATA_W-1:0]     i_item_value,
    input  wire logic [oal_pkg::POS_W-1:0]             i_position,
    input  wire oal_pkg::t_dp_cmd                      i_cmd,
    output oal_pkg::t_dp_sts                           o_sts,
    output logic                                       o_done,
    output logic [oal_pkg::STAT_W-1:0]                 o_status,
    output logic [oal_pkg::POS_W-1:0]                  o_found_position,
    output logic signed [oal_pkg::DATA_W-1:0]          o_read_value,
    output logic [oal_pkg::POS_W-1:0]                  o_list_length
);

    import oal_pkg::*;

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [REQ_W-1:0]         r_req;
    logic [DATA_W-1:0]        r_val;
    logic [WW-1:0]            r_pos;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic [CW-1:0]            r_hit;
    logic [IW-1:0]            r_cmp_idx;
    logic                     r_cmp_valid;
    logic                     r_pend;
    logic [IW-1:0]            r_pend_addr;
    logic [STAT_W-1:0]        r_st;
    logic                     r_done;
    logic [STAT_W-1:0]        r_status;
    logic [POS_W-1:0]         r_found;
    logic [DATA_W-1:0]        r_rdval;
    logic [POS_W-1:0]         r_len;

    logic [WW-1:0]            n_pos;
    logic [WW-1:0]            cnt_w;
    logic [WW-1:0]            pos_m1;
    logic [DATA_W-1:0]        q;
    logic                     re;
    logic [IW-1:0]            raddr;
    logic                     we;
    logic [IW-1:0]            waddr;
    logic [DATA_W-1:0]        wdata;
    logic                     ok;
    logic                     by_pos;
    logic                     by_match;

    assign cnt_w  = WW'(r_count);
    assign pos_m1 = r_pos - WW'(1);

    always_comb begin
        unique case (i_req_type)
            REQ_INS_FRONT: n_pos = WW'(1);
            REQ_INS_REAR:  n_pos = cnt_w + WW'(1);
            default:       n_pos = WW'(i_position);
        endcase
    end

    always_comb begin
        re    = i_cmd.step_up | i_cmd.step_dn | i_cmd.scan_rd | i_cmd.rd_pos;
        raddr = pos_m1[IW-1:0];
        priority if (i_cmd.step_up) begin
            raddr = IW'(r_idx - CW'(1));
        end else if (i_cmd.step_dn) begin
            raddr = IW'(r_idx + CW'(1));
        end else if (i_cmd.scan_rd) begin
            raddr = r_idx[IW-1:0];
        end
        we    = r_pend | i_cmd.wr_new;
        waddr = r_pend ? r_pend_addr : pos_m1[IW-1:0];
        wdata = r_pend ? q : r_val;
    end

    oal_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    assign o_sts.req      = r_req;
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.ins_bad  = (r_pos == '0) || (r_pos > cnt_w + WW'(1));
    assign o_sts.rd_bad   = (r_pos == '0) || (r_pos > cnt_w);
    assign o_sts.hit      = r_cmp_valid && (q == r_val);
    assign o_sts.scan_end = (r_idx >= r_count);
    assign o_sts.cmp_busy = r_cmp_valid;
    assign o_sts.up_more  = (WW'(r_idx) >= r_pos);
    assign o_sts.dn_more  = (WW'(r_idx) + WW'(1) < cnt_w);

    assign ok       = (r_st == ST_OK);
    assign by_pos   = (r_req == REQ_INS_AT) || (r_req == REQ_INS_FRONT) ||
                      (r_req == REQ_INS_REAR) || (r_req == REQ_READ);
    assign by_match = (r_req == REQ_DELETE) || (r_req == REQ_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan_rd;
            r_pend      <= i_cmd.step_up | i_cmd.step_dn;
            r_done      <= i_cmd.respond;
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_val <= i_item_value;
            r_pos <= n_pos;
        end
        if (i_cmd.st_we) begin
            r_st <= i_cmd.st_code;
        end
        r_pend_addr <= r_idx[IW-1:0];
        r_cmp_idx   <= r_idx[IW-1:0];
        priority if (i_cmd.init_up) begin
            r_idx <= r_count;
        end else if (i_cmd.init_scan) begin
            r_idx <= '0;
        end else if (i_cmd.init_dn) begin
            r_idx <= CW'(r_cmp_idx);
        end else if (i_cmd.step_up) begin
            r_idx <= r_idx - CW'(1);
        end else if (i_cmd.step_dn || i_cmd.scan_rd) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.init_dn) begin
            r_hit <= CW'(r_cmp_idx) + CW'(1);
        end
        if (i_cmd.respond) begin
            r_status <= r_st;
            r_len    <= POS_W'(r_count);
            if (ok && by_pos) begin
                r_found <= POS_W'(r_pos);
            end else if (ok && by_match) begin
                r_found <= POS_W'(r_hit);
            end else begin
                r_found <= '0;
            end
            r_rdval <= (ok && (r_req == REQ_READ)) ? q : '0;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_read_value     = r_rdval;
    assign o_list_length    = r_len;

endmodule

`default_nettype wire

/* rtl/ordered_array_list_unit.sv */
// Channel   Handshake              Words
// request   start / busy           i_req_type, i_item_value, i_position
// result    o_done (one cycle)     o_status, o_found_position, o_read_value, o_list_length
//
// A request is taken when start is high and busy is low, and its result word appears
// on the result ports, marked by o_done for one cycle, and stays there until the next result.
// A read or a rejected request goes from decode straight to the response; a search scans
// the entries from the front. An insert or a delete shifts the entries one at a time,
// since every shifted entry needs one read and one write of the single list memory.
// Reset empties the list at once; the memory contents need no clearing.
// The receiver cannot stall, so the next request may be taken as the result is shown.
`default_nettype none

module ordered_array_list_unit #(
    parameter int unsigned CAPACITY = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [oal_pkg::REQ_W-1:0]             i_req_type,
    input  wire logic signed [oal_pkg::DATA_W-1:0]     i_item_value,
    input  wire logic [oal_pkg::POS_W-1:0]             i_position,
    output logic                                       o_done,
    output logic [oal_pkg::STAT_W-1:0]                 o_status,
    output logic [oal_pkg::POS_W-1:0]                  o_found_position,
    output logic signed [oal_pkg::DATA_W-1:0]          o_read_value,
    output logic [oal_pkg::POS_W-1:0]                  o_list_length
);

    import oal_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    oal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    oal_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_type       (i_req_type),
        .i_item_value     (i_item_value),
        .i_position       (i_position),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_list_length    (o_list_length)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    localparam int LIST_CAPACITY = 256;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         where;
        logic signed [31:0] rd;
        logic [8:0]         len;
    } t_list_word;

    typedef struct packed {
        logic [2:0]         req;
        logic signed [31:0] val;
        logic [8:0]         pos;
        logic               typed;
        t_list_word         word;
    } t_request_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_item_value;
    logic [8:0]         i_position;
    logic               o_done;
    logic [1:0]         o_status;
    logic [8:0]         o_found_position;
    logic signed [31:0] o_read_value;
    logic [8:0]         o_list_length;

    logic signed [31:0] list_mem [0:LIST_CAPACITY-1];
    int                 list_len;
    t_list_word         expected_words [$];
    int                 error_count;
    bit                 idle_on;

    t_request_row opening_rows [0:24] = '{
        '{REQ_READ,      32'sd0,          9'd1,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd0}},
        '{REQ_SEARCH,    32'sd5,          9'd1,   1'b1, '{ST_NOTFOUND, 9'd0, 32'sd0, 9'd0}},
        '{REQ_DELETE,    32'sd5,          9'd1,   1'b1, '{ST_NOTFOUND, 9'd0, 32'sd0, 9'd0}},
        '{REQ_INS_AT,    32'sd9,          9'd0,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd0}},
        '{REQ_INS_AT,    32'sd9,          9'd2,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd0}},
        '{REQ_SPARE_6,   32'shFFFFFFFF,   9'd511, 1'b1, '{ST_OK,       9'd0, 32'sd0, 9'd0}},
        '{REQ_SPARE_7,   32'sd0,          9'd0,   1'b1, '{ST_OK,       9'd0, 32'sd0, 9'd0}},
        '{REQ_INS_AT,    32'sh7FFFFFFF,   9'd1,   1'b1, '{ST_OK,       9'd1, 32'sd0, 9'd1}},
        '{REQ_INS_FRONT, 32'sh80000000,   9'd511, 1'b1, '{ST_OK,       9'd1, 32'sd0, 9'd2}},
        '{REQ_INS_REAR,  32'sd0,          9'd0,   1'b1, '{ST_OK,       9'd3, 32'sd0, 9'd3}},
        '{REQ_INS_AT,    32'shFFFFFFFF,   9'd2,   1'b0, '0},
        '{REQ_READ,      32'sd0,          9'd1,   1'b1,
          '{ST_OK, 9'd1, 32'sh80000000, 9'd4}},
        '{REQ_READ,      32'sd0,          9'd4,   1'b0, '0},
        '{REQ_READ,      32'sd0,          9'd5,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd4}},
        '{REQ_READ,      32'sd0,          9'd511, 1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd4}},
        '{REQ_READ,      32'sd0,          9'd0,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd4}},
        '{REQ_INS_AT,    32'sd1,          9'd6,   1'b1, '{ST_BADPOS,   9'd0, 32'sd0, 9'd4}},
        '{REQ_INS_AT,    32'sd1,          9'd5,   1'b0, '0},
        '{REQ_SEARCH,    32'shFFFFFFFF,   9'd0,   1'b0, '0},
        '{REQ_DELETE,    32'sh7FFFFFFF,   9'd0,   1'b0, '0},
        '{REQ_SEARCH,    32'sh7FFFFFFF,   9'd0,   1'b1, '{ST_NOTFOUND, 9'd0, 32'sd0, 9'd4}},
        '{REQ_INS_FRONT, 32'shFFFFFFFF,   9'd0,   1'b0, '0},
        '{REQ_DELETE,    32'shFFFFFFFF,   9'd0,   1'b0, '0},
        '{REQ_READ,      32'sd0,          9'd2,   1'b0, '0},
        '{REQ_DELETE,    32'sd1,          9'd0,   1'b0, '0}
    };

    ordered_array_list_unit #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req_type(i_req_type),
        .i_item_value(i_item_value),
        .i_position(i_position),
        .o_done(o_done),
        .o_status(o_status),
        .o_found_position(o_found_position),
        .o_read_value(o_read_value),
        .o_list_length(o_list_length)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int find_entry(input logic signed [31:0] val);
        int i;
        for (i = 0; i < list_len; i++) begin
            if (list_mem[i] == val) return i + 1;
        end
        return 0;
    endfunction

    function automatic logic [1:0] insert_entry(input logic signed [31:0] val, input int p,
                                                output int where);
        int i;
        where = 0;
        if (list_len >= LIST_CAPACITY) return ST_FULL;
        if (p < 1 || p > list_len + 1) return ST_BADPOS;
        for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
        list_mem[p-1] = val;
        list_len++;
        where = p;
        return ST_OK;
    endfunction

    function automatic t_list_word apply_list_request(input logic [2:0] req,
                                                      input logic signed [31:0] val,
                                                      input logic [8:0] pos);
        t_list_word w;
        int where;
        int i;
        w = '0;
        where = 0;
        case (req)
            REQ_INS_AT:    w.status = insert_entry(val, int'(pos), where);
            REQ_INS_FRONT: w.status = insert_entry(val, 1, where);
            REQ_INS_REAR:  w.status = insert_entry(val, list_len + 1, where);
            REQ_DELETE: begin
                where = find_entry(val);
                if (where == 0) begin
                    w.status = ST_NOTFOUND;
                end else begin
                    for (i = where - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            REQ_SEARCH: begin
                where = find_entry(val);
                if (where == 0) w.status = ST_NOTFOUND;
            end
            REQ_READ: begin
                if (pos < 1 || int'(pos) > list_len) begin
                    w.status = ST_BADPOS;
                end else begin
                    w.rd = list_mem[pos-1];
                    where = int'(pos);
                end
            end
            default: ;
        endcase
        w.where = where[8:0];
        w.len = list_len[8:0];
        return w;
    endfunction

    function automatic logic [2:0] pick_request(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 40) return REQ_INS_AT;
            if (r < 60) return REQ_INS_FRONT;
            if (r < 80) return REQ_INS_REAR;
            if (r < 86) return REQ_DELETE;
            if (r < 92) return REQ_SEARCH;
            if (r < 98) return REQ_READ;
        end else begin
            if (r < 5)  return REQ_INS_AT;
            if (r < 8)  return REQ_INS_FRONT;
            if (r < 10) return REQ_INS_REAR;
            if (r < 85) return REQ_DELETE;
            if (r < 92) return REQ_SEARCH;
            if (r < 98) return REQ_READ;
        end
        return (r == 98) ? REQ_SPARE_6 : REQ_SPARE_7;
    endfunction

    function automatic logic signed [31:0] pick_value(input logic [2:0] req);
        int r;
        if ((req == REQ_DELETE || req == REQ_SEARCH) && list_len > 0
                && $urandom_range(0, 9) < 9)
            return list_mem[$urandom_range(0, list_len - 1)];
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 7) - 4;
        if (r == 5) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFFFFFF;
                1:       return 32'sh80000000;
                2:       return 32'sd0;
                default: return 32'shFFFFFFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [8:0] pick_position(input logic [2:0] req);
        int top;
        int r;
        if (req != REQ_INS_AT && req != REQ_READ) return 9'($urandom_range(0, 511));
        top = (req == REQ_INS_AT) ? list_len + 1 : list_len;
        r = $urandom_range(0, 19);
        if (r == 0) return 9'd0;
        if (r == 1) return 9'(top + 1);
        if (r == 2) return 9'($urandom_range(0, 511));
        return (top >= 1) ? 9'($urandom_range(1, top)) : 9'd1;
    endfunction

    task automatic send_request(input t_request_row row);
        t_list_word predicted;
        int gap;
        if (idle_on && $urandom_range(0, 99) < 27) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= row.req;
        i_item_value <= row.val;
        i_position <= row.pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_list_request(row.req, row.val, row.pos);
        expected_words.push_back(row.typed ? row.word : predicted);
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_word want;
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected, status %0d, length %0d",
                         $time, o_status, o_list_length);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, o_status);
                    error_count++;
                end
                if (o_found_position !== want.where) begin
                    $display("%0t: found_position expected %0d, got %0d",
                             $time, want.where, o_found_position);
                    error_count++;
                end
                if (o_read_value !== want.rd) begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, want.rd, o_read_value);
                    error_count++;
                end
                if (o_list_length !== want.len) begin
                    $display("%0t: list_length expected %0d, got %0d",
                             $time, want.len, o_list_length);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_request_row row;
        bit grow;
        int full_stay;
        int n;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_SPARE_7;
        i_item_value = '0;
        i_position = '0;
        error_count = 0;
        list_len = 0;
        idle_on = 1'b1;
        grow = 1'b1;
        full_stay = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < 25; n++) send_request(opening_rows[n]);

        // The list is filled to capacity, held there for a while, then emptied again.
        for (n = 0; n < 1000; n++) begin
            idle_on = !(n >= 400 && n < 600);
            if (list_len == LIST_CAPACITY) begin
                full_stay++;
                if (full_stay > 12) grow = 1'b0;
            end
            if (list_len == 0) begin
                grow = 1'b1;
                full_stay = 0;
            end
            row = '0;
            row.req = pick_request(grow);
            row.val = pick_value(row.req);
            row.pos = pick_position(row.req);
            send_request(row);
        end
        start <= 1'b0;

        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
